// ===== sv/tbs_pkg.sv =====
// Shared types and constants for the token bucket shaper.
// Depends on nothing; every other file but tbs_ram imports it.
package tbs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ID_W     = 16;
   localparam int NEED_W   = 8;
   localparam int TOKEN_W  = 8;
   localparam int STATUS_W = 3;
   localparam int QCOUNT_W = 5;
   localparam int ENTRY_W  = ID_W + NEED_W;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_BUCKET_DEPTH = 2'd0;
   localparam logic [TOKEN_W-1:0] BUCKET_DEPTH_RST = 8'd10;

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_ARRIVAL = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_TOKEN_ADDED   = 3'd0,
      ST_TOKEN_DROPPED = 3'd1,
      ST_OVERSIZE      = 3'd2,
      ST_QUEUED        = 3'd3,
      ST_QUEUE_FULL    = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // latch the accepted request
      logic commit;  // apply the step and load the result register
   } dp_cmd_type;

endpackage

// ===== sv/tbs_if.sv =====
// Request and result channel interfaces of the token bucket shaper.
// Depends on tbs_pkg for field widths.
interface tbs_req_if;
   import tbs_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [ID_W-1:0]     packet_id;
   logic [NEED_W-1:0]   tokens_needed;
   modport source (output valid, func, packet_id, tokens_needed, input ready);
   modport sink   (input valid, func, packet_id, tokens_needed, output ready);
endinterface

interface tbs_rsp_if;
   import tbs_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] event_status;
   logic                released;
   logic [ID_W-1:0]     released_id;
   logic [NEED_W-1:0]   released_need;
   logic [TOKEN_W-1:0]  tokens_now;
   logic [QCOUNT_W-1:0] queue_count;
   modport source (output valid, event_status, released, released_id, released_need,
                   tokens_now, queue_count, input ready);
   modport sink   (input valid, event_status, released, released_id, released_need,
                   tokens_now, queue_count, output ready);
endinterface

// ===== sv/token_bucket_shaper.sv =====
// Token bucket shaper: one result per request, registered in the cycle after the
// accepting edge when the result channel is free, else held until it frees up.
// A new request is taken only after the previous step has committed: the FIFO
// head is read from the RAM on the accepting edge, and the step is applied once
// the result slot is free. Depends on tbs_pkg, tbs_if, tbs_ctrl, tbs_dp, tbs_ram.
// Synchronous active-high reset empties the bucket and the FIFO and sets
// bucket_depth to 10; no clearing pass is needed, the request side is ready
// in the first cycle after reset.
module token_bucket_shaper #(
   parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tbs_req_if.sink                           req_chan,
   tbs_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tbs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tbs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tbs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import tbs_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   dp_cmd_type          cmd;
   logic [TOKEN_W-1:0]  depth_ff, depth_in;
   logic                csr_wr;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

   // Configuration register: written in the access phase, always ready.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CSR_BUCKET_DEPTH);
   assign depth_in   = csr_wr ? csr_pwdata[TOKEN_W-1:0] : depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= BUCKET_DEPTH_RST;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Read back the depth; unmapped addresses read as zero.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_BUCKET_DEPTH) begin
         csr_prdata = CSR_DATA_W'(depth_ff);
      end
   end

   // Sequence each request: accept, then commit once the result slot is free.
   tbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Bucket arithmetic, FIFO pointers and the result register.
   tbs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .bucket_depth  (depth_ff),
      .func          (req_chan.func),
      .packet_id     (req_chan.packet_id),
      .tokens_needed (req_chan.tokens_needed),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .event_status  (rsp_chan.event_status),
      .released      (rsp_chan.released),
      .released_id   (rsp_chan.released_id),
      .released_need (rsp_chan.released_need),
      .tokens_now    (rsp_chan.tokens_now),
      .queue_count   (rsp_chan.queue_count)
   );

   // Packet FIFO storage: {id, need} per entry, head read every cycle.
   tbs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   a_depth_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_wr |=> depth_ff == $past(depth_ff))
      else $error("bucket depth changed without a write");
   a_one_per_request: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request accepted before the step committed");
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> depth_ff == $past(csr_pwdata[TOKEN_W-1:0]))
      else $error("bucket depth write lost");
endmodule

// ===== sv/tbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/tbs_ctrl.sv =====
// Controller of the token bucket shaper: request/result handshake sequencing.
// Depends on tbs_pkg for the datapath command struct.
module tbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tbs_pkg::dp_cmd_type cmd
);
   import tbs_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign cmd.load   = req_valid && req_ready;
   assign cmd.commit = (state_ff == S_EXEC) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_EXEC)
      else $error("accepted request did not start execution");
   a_commit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed step produced no result");
   a_no_commit_in_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !cmd.load)
      else $error("load and commit in the same cycle");
endmodule

// ===== sv/tbs_dp.sv =====
// Datapath of the token bucket shaper: bucket, FIFO pointers, result register.
// Depends on tbs_pkg; drives the FIFO storage in tbs_ram.
module tbs_dp #(
   parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tbs_pkg::dp_cmd_type            cmd,
   input  logic [tbs_pkg::TOKEN_W-1:0]    bucket_depth,
   input  logic                           func,
   input  logic [tbs_pkg::ID_W-1:0]       packet_id,
   input  logic [tbs_pkg::NEED_W-1:0]     tokens_needed,
   output logic                           ram_we,
   output logic [AW-1:0]                  ram_waddr,
   output logic [tbs_pkg::ENTRY_W-1:0]    ram_wdata,
   output logic [AW-1:0]                  ram_raddr,
   input  logic [tbs_pkg::ENTRY_W-1:0]    ram_rdata,
   output logic [tbs_pkg::STATUS_W-1:0]   event_status,
   output logic                           released,
   output logic [tbs_pkg::ID_W-1:0]       released_id,
   output logic [tbs_pkg::NEED_W-1:0]     released_need,
   output logic [tbs_pkg::TOKEN_W-1:0]    tokens_now,
   output logic [tbs_pkg::QCOUNT_W-1:0]   queue_count
);
   import tbs_pkg::*;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   // latched request
   logic               func_ff;
   logic [ID_W-1:0]    id_ff;
   logic [NEED_W-1:0]  need_ff;

   // bucket and FIFO control state
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [AW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   // result register
   status_type         status_ff, status_in;
   logic               rel_ff, rel_in;
   logic [ID_W-1:0]    rel_id_ff, rel_id_in;
   logic [NEED_W-1:0]  rel_need_ff, rel_need_in;
   logic [TOKEN_W-1:0] tok_out_ff;
   logic [QCOUNT_W-1:0] qcnt_ff;

   logic [ID_W-1:0]    head_id;
   logic [NEED_W-1:0]  head_need;
   logic [TOKEN_W-1:0] tok_tick, tok_base;
   logic               tick_room, empty, full, oversize, push;
   logic [CW+QCOUNT_W-1:0] cnt_wide;

   assign head_id   = ram_rdata[ENTRY_W-1:NEED_W];
   assign head_need = ram_rdata[NEED_W-1:0];
   assign tick_room = tok_ff < bucket_depth;
   assign tok_tick  = tick_room ? tok_ff + TOKEN_W'(1) : tok_ff;
   assign empty     = (cnt_ff == '0);
   assign full      = (cnt_ff == CW'(QUEUE_DEPTH));
   assign oversize  = need_ff > bucket_depth;

   always_comb begin
      status_in   = ST_TOKEN_ADDED;
      rel_in      = 1'b0;
      rel_id_in   = '0;
      rel_need_in = '0;
      tok_base    = tok_ff;
      push        = 1'b0;
      if (func_ff == FUNC_TICK) begin
         status_in = tick_room ? ST_TOKEN_ADDED : ST_TOKEN_DROPPED;
         tok_base  = tok_tick;
         if (!empty && tok_tick >= head_need) begin
            rel_in      = 1'b1;
            rel_id_in   = head_id;
            rel_need_in = head_need;
         end
      end else if (oversize) begin
         status_in = ST_OVERSIZE;
      end else if (full) begin
         status_in = ST_QUEUE_FULL;
      end else begin
         status_in = ST_QUEUED;
         push      = 1'b1;
         // new packet becomes the head at once when the queue was empty
         if (empty && tok_ff >= need_ff) begin
            rel_in      = 1'b1;
            rel_id_in   = id_ff;
            rel_need_in = need_ff;
         end
      end
      tok_in  = rel_in ? tok_base - rel_need_in : tok_base;
      head_in = rel_in ? next_slot(head_ff) : head_ff;
      tail_in = push ? next_slot(tail_ff) : tail_ff;
      cnt_in  = cnt_ff;
      if (push && !rel_in) cnt_in = cnt_ff + CW'(1);
      if (rel_in && !push) cnt_in = cnt_ff - CW'(1);
   end

   assign cnt_wide = (CW + QCOUNT_W)'(cnt_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.commit) begin
         tok_ff  <= tok_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func;
         id_ff   <= packet_id;
         need_ff <= tokens_needed;
      end
      if (cmd.commit) begin
         status_ff   <= status_in;
         rel_ff      <= rel_in;
         rel_id_ff   <= rel_id_in;
         rel_need_ff <= rel_need_in;
         tok_out_ff  <= tok_in;
         qcnt_ff     <= cnt_wide[QCOUNT_W-1:0];
      end
   end

   assign ram_we    = cmd.commit && push;
   assign ram_waddr = tail_ff;
   assign ram_wdata = {id_ff, need_ff};
   assign ram_raddr = head_ff;

   assign event_status  = status_ff;
   assign released      = rel_ff;
   assign released_id   = rel_id_ff;
   assign released_need = rel_need_ff;
   assign tokens_now    = tok_out_ff;
   assign queue_count   = qcnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == CW'(QUEUE_DEPTH)) |-> head_ff == tail_ff)
      else $error("pointers disagree with queue count");
   a_release_tokens: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && rel_in) |=> tok_ff == $past(tok_base) - $past(rel_need_in))
      else $error("release did not take its need from the bucket");
   a_no_release_fields: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !rel_in) |=> (rel_id_ff == '0 && rel_need_ff == '0))
      else $error("release fields set without a release");
endmodule

// ===== tb/sv/tbs_shaper_checker.sv =====
// Scoreboard for the token bucket shaper: tracks bucket and packet FIFO state from the
// accepted requests and register writes, and checks every accepted result in order.
// Depends on tbs_pkg and the tbs_req_if / tbs_rsp_if channel interfaces.
module tbs_shaper_checker (
   input  logic                           clock,
   input  logic                           reset,
   tbs_req_if                             req_mon,
   tbs_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [tbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             fail_count,
   output int                             pending_results,
   output int                             queued_packets
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbs_pkg::*;

   localparam int QDEPTH = QUEUE_DEPTH_DEF;

   typedef struct packed {
      status_type          status;
      logic                released;
      logic [ID_W-1:0]     rel_id;
      logic [NEED_W-1:0]   rel_need;
      logic [TOKEN_W-1:0]  tokens;
      logic [QCOUNT_W-1:0] qcount;
   } shaper_event_type;

   logic [TOKEN_W-1:0] bucket_limit;
   logic [TOKEN_W-1:0] bucket_tokens;
   logic [ID_W-1:0]    pkt_ids   [QDEPTH];
   logic [NEED_W-1:0]  pkt_needs [QDEPTH];
   int                 head_slot;
   int                 tail_slot;
   int                 waiting;
   shaper_event_type   expected_events [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Pop the head packet when the bucket covers its need.
   task automatic release_head(inout shaper_event_type ev);
      if (waiting != 0 && bucket_tokens >= pkt_needs[head_slot]) begin
         ev.released   = 1'b1;
         ev.rel_id     = pkt_ids[head_slot];
         ev.rel_need   = pkt_needs[head_slot];
         bucket_tokens = bucket_tokens - pkt_needs[head_slot];
         head_slot     = (head_slot + 1) % QDEPTH;
         waiting--;
      end
   endtask

   task automatic predict_shaper_step(input logic func, input logic [ID_W-1:0] pid,
                                      input logic [NEED_W-1:0] need);
      shaper_event_type ev;
      ev = '0;
      if (func == FUNC_TICK) begin
         if (bucket_tokens < bucket_limit) begin
            bucket_tokens++;
            ev.status = ST_TOKEN_ADDED;
         end else begin
            ev.status = ST_TOKEN_DROPPED;
         end
         release_head(ev);
      end else if (need > bucket_limit) begin
         ev.status = ST_OVERSIZE;
      end else if (waiting >= QDEPTH) begin
         ev.status = ST_QUEUE_FULL;
      end else begin
         pkt_ids[tail_slot]   = pid;
         pkt_needs[tail_slot] = need;
         tail_slot            = (tail_slot + 1) % QDEPTH;
         waiting++;
         ev.status = ST_QUEUED;
         // only a packet landing in an empty FIFO may leave in the same step
         if (waiting == 1) release_head(ev);
      end
      ev.tokens = bucket_tokens;
      ev.qcount = waiting[QCOUNT_W-1:0];
      expected_events.push_back(ev);
   endtask

   always @(posedge clock) begin
      shaper_event_type want;
      if (reset) begin
         bucket_limit  = BUCKET_DEPTH_RST;
         bucket_tokens = '0;
         head_slot     = 0;
         tail_slot     = 0;
         waiting       = 0;
         fail_count    = 0;
         expected_events.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_BUCKET_DEPTH)
            bucket_limit = csr_pwdata[TOKEN_W-1:0];
         if (req_mon.valid && req_mon.ready)
            predict_shaper_step(req_mon.func, req_mon.packet_id, req_mon.tokens_needed);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("result with no request pending, event_status",
                               rsp_mon.event_status, '0);
            end else begin
               want = expected_events.pop_front();
               if (rsp_mon.event_status !== want.status)
                  report_mismatch("event_status", rsp_mon.event_status, want.status);
               if (rsp_mon.released !== want.released)
                  report_mismatch("released", rsp_mon.released, want.released);
               if (rsp_mon.released_id !== want.rel_id)
                  report_mismatch("released_id", rsp_mon.released_id, want.rel_id);
               if (rsp_mon.released_need !== want.rel_need)
                  report_mismatch("released_need", rsp_mon.released_need, want.rel_need);
               if (rsp_mon.tokens_now !== want.tokens)
                  report_mismatch("tokens_now", rsp_mon.tokens_now, want.tokens);
               if (rsp_mon.queue_count !== want.qcount)
                  report_mismatch("queue_count", rsp_mon.queue_count, want.qcount);
            end
         end
      end
      pending_results = expected_events.size();
      queued_packets  = waiting;
   end

endmodule

// ===== tb/sv/token_bucket_shaper_tb.sv =====
// Top of the token bucket shaper testbench: clock, reset, request and result traffic,
// register writes, and the final verdict. Depends on tbs_pkg, tbs_if,
// token_bucket_shaper and tbs_shaper_checker.
module token_bucket_shaper_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbs_pkg::*;

   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 150;
   localparam int HOLD_OFF_LEN = 300;
   localparam int DRAIN_CAP    = 4096;
   // Bucket depth per random phase: both extremes, a few in between, then back to reset.
   localparam int PHASE_DEPTH [PHASE_COUNT] = '{255, 0, 3, 40, 1, 10};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending_results;
   int queued_packets;

   // Traffic shaping knobs, changed per phase by the stimulus process.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int rsp_hold_cycles    = 0;
   int bucket_depth_now   = BUCKET_DEPTH_RST;

   tbs_req_if req_chan ();
   tbs_rsp_if rsp_chan ();

   token_bucket_shaper i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tbs_shaper_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .queued_packets  (queued_packets)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest correct run.
   initial begin
      #6ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random stalls per cycle, plus a long hold-off when the stimulus asks
   // for one. The hold-off is counted here so the sender keeps pushing meanwhile.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until the block takes it. Random idle cycles go
   // in front of it so that gaps land on every phase of the block's request step.
   task automatic send_request(input logic func, input logic [ID_W-1:0] pid,
                               input logic [NEED_W-1:0] need);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.func          <= func;
      req_chan.packet_id     <= pid;
      req_chan.tokens_needed <= need;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_tick();
      // the id and need fields are don't-care on a tick; keep them moving anyway
      send_request(FUNC_TICK, ID_W'($urandom), NEED_W'($urandom));
   endtask

   // Wait for a clock edge first so the scoreboard has seen the last accepted request.
   task automatic wait_results_drained();
      @(posedge clock);
      wait (pending_results == 0);
   endtask

   // Rewrite the bucket depth only with the block idle: drop valid, let every
   // outstanding result come back, then run a setup and an access cycle.
   task automatic write_bucket_depth(input int depth);
      req_chan.valid <= 1'b0;
      wait_results_drained();
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_BUCKET_DEPTH;
      // upper bits are junk on purpose; only the low byte lands in the register
      csr_pwdata  <= {24'($urandom), 8'(depth)};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      bucket_depth_now = depth;
   endtask

   // Feed ticks one at a time until the FIFO is empty (or DRAIN_CAP ticks have gone
   // in), so the next depth setting starts from a clean queue.
   task automatic drain_queue();
      int n;
      n = 0;
      req_chan.valid <= 1'b0;
      wait_results_drained();
      while (queued_packets != 0 && n < DRAIN_CAP) begin
         send_tick();
         req_chan.valid <= 1'b0;
         wait_results_drained();
         n++;
      end
   endtask

   // Random traffic. The arrival share changes in bursts so the FIFO both empties
   // out and fills to the brim; needs lean small against the current depth so
   // packets actually leave, with a tail of oversize and zero-need packets.
   task automatic run_random_phase(input int count);
      int i;
      int pick;
      int arrival_pct;
      int small_top;
      logic [NEED_W-1:0] need;
      arrival_pct = 50;
      small_top   = (bucket_depth_now < 8) ? bucket_depth_now : 8;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(3))
               0: arrival_pct = 25;
               1: arrival_pct = 50;
               2: arrival_pct = 75;
               default: arrival_pct = 90;
            endcase
         end
         if ($urandom_range(99) < arrival_pct) begin
            pick = $urandom_range(99);
            if (pick < 10)      need = '0;
            else if (pick < 60) need = NEED_W'($urandom_range(small_top));
            else if (pick < 85) need = NEED_W'($urandom_range(bucket_depth_now));
            else                need = NEED_W'($urandom_range(255));
            send_request(FUNC_ARRIVAL, ID_W'($urandom), need);
         end else begin
            send_tick();
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      int phase;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.func          <= FUNC_TICK;
      req_chan.packet_id     <= '0;
      req_chan.tokens_needed <= '0;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset depth of 10, bucket and FIFO empty.
      // Tick with all-ones in the ignored fields: one token goes in.
      send_request(FUNC_TICK, '1, '1);
      // Zero-need packet into an empty FIFO leaves in the same step.
      send_request(FUNC_ARRIVAL, '0, '0);
      // Need just above the depth, then the largest need: both dropped as oversize.
      send_request(FUNC_ARRIVAL, 16'h1234, 8'd11);
      send_request(FUNC_ARRIVAL, '1, '1);
      // Need equal to the depth: queued, stalls at the head.
      send_request(FUNC_ARRIVAL, '1, 8'd10);
      // Zero-need packet stuck behind it.
      send_request(FUNC_ARRIVAL, 16'h0001, '0);
      repeat (6) send_tick();
      // Lower the depth under both the token count and the head need: the next tick
      // drops its token, the count stays above the depth, the head keeps waiting.
      write_bucket_depth(5);
      send_tick();
      // Restore the depth: three ticks fill the bucket and free the head, the next
      // tick releases the zero-need packet behind it.
      write_bucket_depth(BUCKET_DEPTH_RST);
      repeat (4) send_tick();

      // Random phases, each with its own depth and idling pattern.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_bucket_depth(PHASE_DEPTH[phase]);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 69;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 69;
            end
            default: begin
               sender_idle_pct    = 14;
               receiver_stall_pct = 14;
            end
         endcase
         // Back-pressure: hold the result side off while requests keep coming,
         // so the block fills up and stops taking requests.
         if (phase == 0) rsp_hold_cycles = HOLD_OFF_LEN;
         run_random_phase(PHASE_ITEMS);
         drain_queue();
      end

      // Wrap up: let everything come back, then give a stray result time to show.
      req_chan.valid <= 1'b0;
      wait_results_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
